### rtl/core/s256md_pkg.sv
// package: word types, initial hash values and round constants for the digest core
`timescale 1ns / 1ps

package s256md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenStart = 56;

  localparam hash_t InitHash = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam logic [7:0] PadMarker = 8'h80;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/sha256_message_digest.sv
// top level: byte-serial sha-256 digest with a single shared round unit
`timescale 1ns / 1ps

// Message bytes enter one item at a time and are packed big-endian; an item
// may carry a byte, an end mark or both (byte first). A byte that does not
// complete a 64-byte block is taken without a stall. A byte that completes a
// block starts a compression: 64 rounds of the shared round unit, one round
// per cycle, then a fold of the working variables into the hash, with the
// input stalled throughout. At message end the padding bytes (0x80, zeros,
// then the 64-bit bit length) are fed through the same byte path at one
// byte a cycle, with one or two compressions on the way, and the eight
// digest words then leave most significant first, one per cycle when the
// output is not stalled. The input is stalled throughout that work. After
// the last word the hash restarts from the standard initial values.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  s256md_pkg::hash_t hash_r, hash_nxt;
  s256md_pkg::hash_t vars_r, vars_nxt;
  s256md_pkg::hash_t vars_rnd;
  s256md_pkg::word_t win_r [16];
  s256md_pkg::word_t win_nxt [16];
  s256md_pkg::word_t w_new;
  logic [23:0] pack_r, pack_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        pad_r, pad_nxt;          // padding in progress for this message
  logic        pad_first_r, pad_first_nxt; // next pad byte is the marker
  logic        len_phase_r, len_phase_nxt; // pad bytes now carry the length

  // shared byte path
  logic       push_en;
  logic [7:0] push_byte;
  logic       block_full;

  logic in_acc;
  logic out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_acc   = out_valid && !out_stall;

  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  assign block_full = push_en && (count_r == 6'(s256md_pkg::BlockBytes - 1));

  s256md_round u_round (
    .vars_i  (vars_r),
    .k_i     (s256md_pkg::round_k(rnd_r)),
    .w0_i    (win_r[0]),
    .w1_i    (win_r[1]),
    .w9_i    (win_r[9]),
    .w14_i   (win_r[14]),
    .vars_o  (vars_rnd),
    .w_new_o (w_new)
  );

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    vars_nxt      = vars_r;
    win_nxt       = win_r;
    pack_nxt      = pack_r;
    count_nxt     = count_r;
    bitlen_nxt    = bitlen_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    pad_nxt       = pad_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    push_en       = 1'b0;
    push_byte     = 8'h00;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            push_en    = 1'b1;
            push_byte  = in_data_byte;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_message_end) begin
            pad_nxt       = 1'b1;
            pad_first_nxt = 1'b1;
            len_phase_nxt = 1'b0;
          end
          if (in_has_byte && count_r == 6'(s256md_pkg::BlockBytes - 1)) begin
            state_nxt = ST_COMP;
          end else if (in_message_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_r) begin
          push_byte = s256md_pkg::PadMarker;
        end else if (len_phase_r) begin
          push_byte = bitlen_r[63:56];
        end
        pad_first_nxt = 1'b0;
        if (len_phase_r && !pad_first_r) begin
          bitlen_nxt = {bitlen_r[55:0], 8'h00};
        end else if (count_r == 6'(s256md_pkg::LenStart - 1)) begin
          // zeros stop at byte 56 of a block
          len_phase_nxt = 1'b1;
        end
        if (count_r == 6'(s256md_pkg::BlockBytes - 1)) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        vars_nxt = vars_rnd;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(s256md_pkg::NumRounds - 1)) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + vars_r[i];
        end
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (len_phase_r && count_r == 6'd0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            hash_nxt      = s256md_pkg::InitHash;
            bitlen_nxt    = 64'd0;
            pad_nxt       = 1'b0;
            pad_first_nxt = 1'b0;
            len_phase_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // big-endian packing, a full word shifts into the schedule window
    if (push_en) begin
      pack_nxt  = {pack_r[15:0], push_byte};
      count_nxt = count_r + 6'd1;
      if (count_r[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {pack_r, push_byte};
      end
    end
    if (block_full) begin
      vars_nxt = hash_r;
      rnd_nxt  = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= s256md_pkg::InitHash;
      vars_r      <= '0;
      count_r     <= '0;
      bitlen_r    <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      pad_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      vars_r      <= vars_nxt;
      count_r     <= count_nxt;
      bitlen_r    <= bitlen_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      pad_r       <= pad_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
    end
  end

  // window and packing register are payload only
  always_ff @(posedge clk) begin
    pack_r <= pack_nxt;
    win_r  <= win_nxt;
  end

endmodule

### rtl/core/s256md_round.sv
// one compression round plus the next message schedule word
`timescale 1ns / 1ps

module s256md_round (
  input  s256md_pkg::hash_t vars_i,
  input  s256md_pkg::word_t k_i,
  input  s256md_pkg::word_t w0_i,
  input  s256md_pkg::word_t w1_i,
  input  s256md_pkg::word_t w9_i,
  input  s256md_pkg::word_t w14_i,
  output s256md_pkg::hash_t vars_o,
  output s256md_pkg::word_t w_new_o
);

  s256md_pkg::word_t a, b, c, d, e, f, g, h;
  s256md_pkg::word_t big0, big1, ch, mj, t1, t2, sm0, sm1;

  always_comb begin
    a = vars_i[0]; b = vars_i[1]; c = vars_i[2]; d = vars_i[3];
    e = vars_i[4]; f = vars_i[5]; g = vars_i[6]; h = vars_i[7];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch   = (e & f) ^ (~e & g);
    mj   = (a & b) ^ (a & c) ^ (b & c);
    t1   = h + big1 + ch + k_i + w0_i;
    t2   = big0 + mj;
    vars_o[7] = g;
    vars_o[6] = f;
    vars_o[5] = e;
    vars_o[4] = d + t1;
    vars_o[3] = c;
    vars_o[2] = b;
    vars_o[1] = a;
    vars_o[0] = t1 + t2;
    // schedule recurrence over the sliding window
    sm0 = {w1_i[6:0], w1_i[31:7]} ^ {w1_i[17:0], w1_i[31:18]} ^ {3'b000, w1_i[31:3]};
    sm1 = {w14_i[16:0], w14_i[31:17]} ^ {w14_i[18:0], w14_i[31:19]}
        ^ {10'b0, w14_i[31:10]};
    w_new_o = sm1 + w9_i + sm0 + w0_i;
  end

endmodule

### dv/sha256_digest_checker.sv
// checker: predicts the digest words from accepted input items and compares the result items
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_message_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          mismatches,
  output int          words_pending
);

  typedef struct packed {
    s256md_pkg::word_t value;
    logic [2:0]        position;
    logic              is_last;
  } digest_item_t;

  localparam logic [0:7][31:0] StartHash = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [0:63][31:0] RoundConst = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  s256md_pkg::word_t digest_state [8];
  s256md_pkg::word_t sched_words [16];
  logic [5:0]        block_fill;
  logic [63:0]       message_bits;
  digest_item_t      awaited_words [$];

  function automatic s256md_pkg::word_t rotr(input s256md_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    s256md_pkg::word_t v [8];
    s256md_pkg::word_t w;
    s256md_pkg::word_t s0;
    s256md_pkg::word_t s1;
    s256md_pkg::word_t t1;
    s256md_pkg::word_t t2;
    for (int i = 0; i < 8; i++) v[i] = digest_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_words[t];
      end else begin
        // window slots for t-15, t-2 and t-7
        s0 = rotr(sched_words[(t + 1) % 16], 7) ^ rotr(sched_words[(t + 1) % 16], 18) ^
             (sched_words[(t + 1) % 16] >> 3);
        s1 = rotr(sched_words[(t + 14) % 16], 17) ^ rotr(sched_words[(t + 14) % 16], 19) ^
             (sched_words[(t + 14) % 16] >> 10);
        w = sched_words[t % 16] + s0 + sched_words[(t + 9) % 16] + s1;
        sched_words[t % 16] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) digest_state[i] = digest_state[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    if (block_fill[1:0] == 2'd0) begin
      sched_words[block_fill[5:2]] = {24'h000000, b};
    end else begin
      sched_words[block_fill[5:2]] = {sched_words[block_fill[5:2]][23:0], b};
    end
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) begin
      compress_block();
    end
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) digest_state[i] = StartHash[i];
    block_fill = 6'd0;
    message_bits = 64'd0;
  endfunction

  function automatic void take_item(input logic [7:0] d, input logic has, input logic fin);
    logic [63:0]  length_bits;
    digest_item_t item;
    if (has) begin
      absorb_byte(d);
      message_bits = message_bits + 64'd8;
    end
    if (fin) begin
      // marker, zero fill up to the length field, then the big-endian bit count
      length_bits = message_bits;
      absorb_byte(8'h80);
      while (block_fill != 6'd56) absorb_byte(8'h00);
      for (int s = 56; s >= 0; s -= 8) absorb_byte(length_bits[s +: 8]);
      for (int i = 0; i < 8; i++) begin
        item.value = digest_state[i];
        item.position = 3'(i);
        item.is_last = (i == 7);
        awaited_words = {awaited_words, item};
      end
      restart_message();
    end
  endfunction

  always @(posedge clk) begin : watch
    digest_item_t want;
    if (!rst_n) begin
      restart_message();
      awaited_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        take_item(in_data_byte, in_has_byte, in_message_end);
      end
      if (out_valid && !out_stall) begin
        if (awaited_words.size() == 0) begin
          $error("digest_word %h arrived with no digest pending", out_digest_word);
          mismatches++;
        end else begin
          want = awaited_words.pop_front();
          if (out_digest_word !== want.value) begin
            $error("digest_word: expected %h, got %h", want.value, out_digest_word);
            mismatches++;
          end
          if (out_word_index !== want.position) begin
            $error("word_index: expected %0d, got %0d", want.position, out_word_index);
            mismatches++;
          end
          if (out_last_word !== want.is_last) begin
            $error("last_word: expected %0b, got %0b", want.is_last, out_last_word);
            mismatches++;
          end
        end
      end
    end
    words_pending <= awaited_words.size();
  end

endmodule

### dv/tb_sha256_message_digest.sv
// testbench top: clock, reset, message stimulus with random idling, and the verdict
`timescale 1ns / 1ps

module tb_sha256_message_digest;

  // item count that ends the random part, and where idling stops
  localparam int ItemTarget = 380;
  localparam int CalmFrom = 330;
  // generous bound for the whole run, message ends and stalls included
  localparam int CycleLimit = 1000000;
  // quiet time after the last digest word to catch stray result items
  localparam int DrainCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_message_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int mismatches;
  int words_pending;
  int items_sent = 0;
  int cycle_count = 0;
  // set near the end of the run: no idling on either side from then on
  bit calm = 1'b0;

  always #5 clk = ~clk;

  sha256_message_digest u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  sha256_digest_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .mismatches     (mismatches),
    .words_pending  (words_pending)
  );

  // offer one item and hold it until the block takes it; valid is left high so
  // that a following item goes out back to back, and only an idle burst lowers it
  task automatic send_item(input logic [7:0] d, input logic has, input logic fin);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_has_byte <= has;
    in_message_end <= fin;
    do @(posedge clk); while (in_stall);
    // items with neither byte nor end are ignored by the block, so not counted
    if (has || fin) items_sent++;
    calm = (items_sent >= CalmFrom);
  endtask

  // one message of random bytes; the end rides on the last byte or comes alone
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // result side back-pressure: random stall bursts with free stretches between
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // run limit: a hang anywhere ends here
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int len;
    int pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty message straight after reset, then again back to back
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    // an ignored item, then a byte and the end together at the top byte value
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    // the classic three-letter message, end as a separate item
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // lowest byte value with the end on it
    send_item(8'h00, 1'b1, 1'b1);
    // ignored item carrying all ones, then bytes at both extremes and the pad marker value
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);

    // random messages: mostly short, some medium, a few around the block edges
    // where the padding spills into an extra block or the block fills exactly
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 12);
      end else if (pick < 88) begin
        len = $urandom_range(13, 40);
      end else begin
        case ($urandom_range(0, 4))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          default: len = 119;
        endcase
      end
      send_message(len, $urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    // wait for the last digest, then a quiet stretch for anything unexpected
    do @(posedge clk); while (words_pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sha256_message_digest.f
rtl/core/s256md_pkg.sv
rtl/core/s256md_round.sv
rtl/core/sha256_message_digest.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_message_digest.sv
